// ===== rtl/core/tea_pkg.sv =====
// Shared types and constants for the TEA block cipher pipeline.
package tea_pkg;

    localparam int          ROUNDS     = 32;
    localparam int          NUM_CELLS  = 2 * ROUNDS;
    localparam int          WORD_W     = 32;
    localparam int          NUM_KEYS   = 4;
    localparam int          KEY_IDX_W  = 2;
    localparam logic [31:0] TEA_DELTA  = 32'h9E37_79B9;
    // Starting sum for decryption: delta times the round count, modulo 2^32.
    localparam logic [31:0] SUM_DEC    = 32'(64'(TEA_DELTA) * 64'(ROUNDS));

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } tea_op_t;

    typedef enum logic [KEY_IDX_W-1:0] {
        KEY_WORD_0 = 2'd0,
        KEY_WORD_1 = 2'd1,
        KEY_WORD_2 = 2'd2,
        KEY_WORD_3 = 2'd3
    } tea_key_idx_t;

    // Block state handed from one half-round cell to the next.
    typedef struct packed {
        tea_op_t           op;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic [WORD_W-1:0] sum;
    } tea_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] k3;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k0;
    } tea_key_t;

    // TEA round function of one half.
    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

// ===== rtl/core/tea_key_regs.sv =====
// Key register file written through the configuration port.
module tea_key_regs
    import tea_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    output tea_key_t             key
);

    tea_key_t key_reg;
    tea_key_t key_next;

    always_comb begin
        key_next = key_reg;
        if (cfg_we) begin
            unique case (tea_key_idx_t'(cfg_index))
                KEY_WORD_0: key_next.k0 = cfg_wdata;
                KEY_WORD_1: key_next.k1 = cfg_wdata;
                KEY_WORD_2: key_next.k2 = cfg_wdata;
                KEY_WORD_3: key_next.k3 = cfg_wdata;
                default:    key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

// ===== rtl/core/tea_round_cell.sv =====
// One TEA half-round cell with its own valid/ready handshake.
module tea_round_cell
    import tea_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      phase,      // 0 first half-round, 1 second half-round
    input  tea_key_t  key,
    input  logic      in_valid,
    output logic      in_ready,
    input  tea_word_t in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output tea_word_t out_word
);

    logic              valid_reg;
    tea_word_t         word_reg;
    tea_word_t         word_next;
    logic              upd_left;
    logic [WORD_W-1:0] mix_val;

    // The left half is updated in the first half-round of encryption and the
    // second half-round of decryption; the right half otherwise.
    assign upd_left = (phase == (in_word.op == OP_DECRYPT));

    assign mix_val = upd_left ? tea_mix(in_word.right, in_word.sum, key.k0, key.k1)
                              : tea_mix(in_word.left,  in_word.sum, key.k2, key.k3);

    always_comb begin
        word_next = in_word;
        if (upd_left) begin
            word_next.left = (in_word.op == OP_DECRYPT) ? in_word.left - mix_val
                                                        : in_word.left + mix_val;
        end else begin
            word_next.right = (in_word.op == OP_DECRYPT) ? in_word.right - mix_val
                                                         : in_word.right + mix_val;
        end
        // The sum steps once per full round, after the second half.
        if (phase) begin
            word_next.sum = (in_word.op == OP_DECRYPT) ? in_word.sum - TEA_DELTA
                                                       : in_word.sum + TEA_DELTA;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/core/tea_block_cipher_top.sv =====
// Top level of the pipelined TEA block cipher.
//
// The slave channel takes one 64-bit block per word: s_tdata carries the two
// 32-bit halves and s_tuser selects encryption (0) or decryption (1). The
// master channel returns the transformed block in the same layout on m_tdata.
// Each block yields exactly one result word, and results leave in the order
// the blocks came in.
//
// The datapath is a chain of 64 identical half-round cells, two per TEA round.
// Every cell holds one block in flight and hands it to its neighbor each cycle
// while m_tready stays high, so a new block is then accepted every cycle. A
// block passes through all 64 cell registers on its way to m_tvalid. The
// half-round adder path in each cell sets the clock period.
//
// The 128-bit key lives in four 32-bit registers written through cfg_we,
// cfg_index and cfg_wdata. A reset clears the key to zero and empties the
// pipeline. When the receiver holds m_tready low, cells stall from the output
// backward; empty cells ahead of a stall keep filling, so the block keeps
// accepting words until the chain is full, and no word is lost or duplicated.
module tea_block_cipher_top
    import tea_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    // Input blocks.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // [31:0] block_left, [63:32] block_right
    input  logic                 s_tuser,   // [0] op
    // Result blocks.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata    // [31:0] out_left, [63:32] out_right
);

    tea_key_t  key;
    logic      stage_valid [NUM_CELLS+1];
    logic      stage_ready [NUM_CELLS+1];
    tea_word_t stage_word  [NUM_CELLS+1];

    tea_key_regs u_key_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key       (key)
    );

    // Entry into the chain: the running sum starts at delta for encryption
    // and at delta times the round count for decryption.
    always_comb begin
        stage_word[0].op    = tea_op_t'(s_tuser);
        stage_word[0].left  = s_tdata[WORD_W-1:0];
        stage_word[0].right = s_tdata[2*WORD_W-1:WORD_W];
        stage_word[0].sum   = (tea_op_t'(s_tuser) == OP_DECRYPT) ? SUM_DEC : TEA_DELTA;
    end

    assign stage_valid[0] = s_tvalid;
    assign s_tready       = stage_ready[0];

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        tea_round_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .phase     (1'(c % 2)),
            .key       (key),
            .in_valid  (stage_valid[c]),
            .in_ready  (stage_ready[c]),
            .in_word   (stage_word[c]),
            .out_valid (stage_valid[c+1]),
            .out_ready (stage_ready[c+1]),
            .out_word  (stage_word[c+1])
        );
    end

    assign stage_ready[NUM_CELLS] = m_tready;
    assign m_tvalid = stage_valid[NUM_CELLS];
    assign m_tdata  = {stage_word[NUM_CELLS].right, stage_word[NUM_CELLS].left};

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the pipelined TEA block cipher top level.
module tb_top;
    import tea_pkg::*;

    // Generous cycle budget for a clean run, even when both sides of the cipher
    // idle at random.
    localparam int CYCLE_LIMIT   = 400000;
    // Quiet time after the last result, sized from the 64-cell pipeline depth.
    localparam int DRAIN_CYCLES  = 2 * NUM_CELLS;
    localparam int PHASE_BLOCKS  = 250;
    localparam int RANDOM_PHASES = 7;

    typedef struct {
        tea_op_t           op;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } block_t;

    typedef struct {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } halves_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [KEY_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;   // [31:0] block_left, [63:32] block_right
    logic                 s_tuser   = 1'b0; // [0] op
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // [31:0] out_left, [63:32] out_right

    // Shadow copy of the key registers, updated as the key is written.
    logic [WORD_W-1:0] key_shadow [NUM_KEYS] = '{default: '0};

    // Blocks waiting to be driven, and the transformed blocks the cipher owes us.
    block_t  blocks_to_send[$];
    halves_t owed_ciphertexts[$];

    // Progress counters for the stimulus thread and driver, plus error and cycle counts.
    int unsigned blocks_queued   = 0;
    int unsigned blocks_accepted = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    // Random idling switches, changed only between phases.
    bit send_gaps   = 1'b1;
    bit recv_stalls = 1'b1;

    tea_block_cipher_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // One TEA half-round function, written with explicit bit slicing.
    function automatic logic [WORD_W-1:0] round_f(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] acc,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ({x[WORD_W-5:0], 4'b0000} + ka) ^ (x + acc) ^ ({5'b00000, x[WORD_W-1:5]} + kb);
    endfunction

    // Full 32-round TEA transform of one block under the shadow key.
    function automatic halves_t cipher_block(input block_t blk);
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] acc;
        halves_t           res;
        y = blk.left;
        z = blk.right;
        if (blk.op == OP_ENCRYPT) begin
            acc = '0;
            for (int r = 0; r < ROUNDS; r++) begin
                acc = acc + TEA_DELTA;
                y   = y + round_f(z, acc, key_shadow[0], key_shadow[1]);
                z   = z + round_f(y, acc, key_shadow[2], key_shadow[3]);
            end
        end else begin
            // The decrypt schedule starts from delta times the round count and
            // walks the sum back down, undoing the rounds in reverse.
            acc = TEA_DELTA * WORD_W'(ROUNDS);
            for (int r = 0; r < ROUNDS; r++) begin
                z   = z - round_f(y, acc, key_shadow[2], key_shadow[3]);
                y   = y - round_f(z, acc, key_shadow[0], key_shadow[1]);
                acc = acc - TEA_DELTA;
            end
        end
        res.left  = y;
        res.right = z;
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] random_half();
        logic [WORD_W-1:0] corners [5] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                            32'h0000_0001, 32'h7FFF_FFFF};
        if ($urandom_range(9) == 0)
            return corners[$urandom_range(4)];
        return $urandom;
    endfunction

    task automatic queue_block(input tea_op_t op, input logic [WORD_W-1:0] l,
                               input logic [WORD_W-1:0] r);
        block_t blk;
        blk.op    = op;
        blk.left  = l;
        blk.right = r;
        blocks_to_send.push_back(blk);
        blocks_queued++;
    endtask

    // Encrypt a block and then decrypt its ciphertext; the second word must
    // come back as the original plaintext.
    task automatic queue_round_trip(input logic [WORD_W-1:0] l, input logic [WORD_W-1:0] r);
        block_t  plain;
        halves_t ct;
        plain.op    = OP_ENCRYPT;
        plain.left  = l;
        plain.right = r;
        ct = cipher_block(plain);
        queue_block(OP_ENCRYPT, l, r);
        queue_block(OP_DECRYPT, ct.left, ct.right);
    endtask

    task automatic write_key_word(input tea_key_idx_t idx, input logic [WORD_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        key_shadow[idx] = val;
    endtask

    task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                            input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
        write_key_word(KEY_WORD_0, k0);
        write_key_word(KEY_WORD_1, k1);
        write_key_word(KEY_WORD_2, k2);
        write_key_word(KEY_WORD_3, k3);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Holds the stimulus thread until every queued block has been accepted
    // and every owed result has come back. Only then is the key touched.
    task automatic wait_until_drained();
        while (blocks_accepted != blocks_queued || owed_ciphertexts.size() != 0)
            @(posedge aclk);
    endtask

    // Stimulus: a directed phase under the reset key, then random phases,
    // each under a fresh key and each drained before the key changes.
    initial begin
        static logic [WORD_W-1:0] edge_vals [6][2] = '{
            '{32'h0000_0000, 32'h0000_0000}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
            '{32'h0000_0000, 32'hFFFF_FFFF}, '{32'hFFFF_FFFF, 32'h0000_0000},
            '{32'h8000_0000, 32'h0000_0001}, '{32'h0000_0001, 32'h8000_0000}};
        int unsigned target;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed phase: the key is still all zeros from reset. Both operations
        // see the extreme halves, and two round trips check that decrypt undoes
        // encrypt.
        for (int i = 0; i < 6; i++) begin
            queue_block(OP_ENCRYPT, edge_vals[i][0], edge_vals[i][1]);
            queue_block(OP_DECRYPT, edge_vals[i][0], edge_vals[i][1]);
        end
        queue_round_trip(32'h0123_4567, 32'h89AB_CDEF);
        queue_round_trip($urandom, $urandom);
        wait_until_drained();

        for (int p = 1; p <= RANDOM_PHASES; p++) begin
            case (p)
                1: begin
                    load_key('1, '1, '1, '1);
                end
                2: begin
                    load_key('0, '1, '0, '1);
                end
                3: begin
                    load_key('1, '0, '1, '0);
                end
                RANDOM_PHASES: begin
                    load_key('0, '0, '0, '0);
                end
                default: begin
                    load_key($urandom, $urandom, $urandom, $urandom);
                end
            endcase

            // Phase 3 runs at full rate on both sides; phase 5 stalls only the
            // receiver so the pipeline backs up into a busy sender.
            send_gaps   = (p != 3) && (p != 5);
            recv_stalls = (p != 3);

            target = blocks_queued + PHASE_BLOCKS;
            while (blocks_queued < target) begin
                if ($urandom_range(7) == 0)
                    queue_round_trip(random_half(), random_half());
                else
                    queue_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT,
                                random_half(), random_half());
            end
            wait_until_drained();
        end

        // Let anything the cipher should not have produced show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && owed_ciphertexts.size() == 0) begin
            $display("PASS tea_block_cipher_top");
        end else begin
            $display("FAIL tea_block_cipher_top");
        end
        $finish;
    end

    // Driver: presents the next queued block whenever the slave channel is
    // free, idling at random while gaps are enabled. The expected result is
    // computed at the edge where the word is accepted.
    block_t staged_block;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                owed_ciphertexts.push_back(cipher_block(staged_block));
                blocks_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (blocks_to_send.size() != 0 && !(send_gaps && $urandom_range(99) < 22)) begin
                    staged_block = blocks_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {staged_block.right, staged_block.left};
                    s_tuser  <= staged_block.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every accepted result word with the oldest owed block
    // and drives m_tready, stalling it at random while receiver stalls are enabled.
    always @(posedge aclk) begin
        halves_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_ciphertexts.size() == 0) begin
                    $error("result word %h arrived with no block outstanding", m_tdata);
                    error_count++;
                end else begin
                    want = owed_ciphertexts.pop_front();
                    if (m_tdata[31:0] !== want.left) begin
                        $error("out_left mismatch: expected %h, actual %h",
                               want.left, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[63:32] !== want.right) begin
                        $error("out_right mismatch: expected %h, actual %h",
                               want.right, m_tdata[63:32]);
                        error_count++;
                    end
                end
            end
            m_tready <= recv_stalls ? ($urandom_range(99) >= 22) : 1'b1;
        end
    end

    // Watchdog against a hung pipeline or a lost handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL tea_block_cipher_top");
            $finish;
        end
    end

endmodule
